// ===== hw/rtl/ssa_pkg.sv =====
`default_nettype none
package ssa_pkg;
    localparam int unsigned WIDTH_DEF = 32;
    localparam int unsigned CMD_W = 3;
    localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MOD = 3'd4;
endpackage
`default_nettype wire

// ===== hw/rtl/ssa_if.sv =====
`default_nettype none
interface ssa_req_if #(parameter int unsigned WIDTH = 32);
    logic              valid;
    logic              ready;
    logic [2:0]        cmd;
    logic signed [WIDTH-1:0] a;
    logic signed [WIDTH-1:0] b;
    modport source (output valid, cmd, a, b, input ready);
    modport sink (input valid, cmd, a, b, output ready);
endinterface

interface ssa_rsp_if #(parameter int unsigned WIDTH = 32);
    logic              valid;
    logic              ready;
    logic signed [WIDTH-1:0] result;
    logic              carry;
    logic              div_by_zero;
    modport source (output valid, result, carry, div_by_zero, input ready);
    modport sink (input valid, result, carry, div_by_zero, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ssa_cell.sv =====
`default_nettype none
module ssa_cell #(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic             i_is_div,
    input  wire logic [WIDTH:0]   i_acc,
    input  wire logic [WIDTH:0]   i_x,
    input  wire logic [WIDTH:0]   i_y,
    input  wire logic [WIDTH-1:0] i_side,
    output logic                  o_valid,
    output logic                  o_is_div,
    output logic [WIDTH:0]        o_acc,
    output logic [WIDTH:0]        o_x,
    output logic [WIDTH:0]        o_y,
    output logic [WIDTH-1:0]      o_side
);
    // Divide: acc is partial remainder, x holds dividend bits shifting out / quotient in.
    // Multiply: acc is partial product, x multiplier shifting right, y multiplicand shifting left.
    logic [WIDTH+1:0] n_rem;
    logic [WIDTH+1:0] n_dif;
    logic [WIDTH:0]   n_acc;
    logic [WIDTH:0]   n_x;
    logic [WIDTH:0]   n_y;

    always_comb begin
        n_rem = {i_acc, i_x[WIDTH]};
        n_dif = n_rem - {1'b0, i_y};
        n_y   = i_y;
        if (i_is_div) begin
            if (!n_dif[WIDTH+1]) begin
                n_acc = n_dif[WIDTH:0];
                n_x   = {i_x[WIDTH-1:0], 1'b1};
            end else begin
                n_acc = n_rem[WIDTH:0];
                n_x   = {i_x[WIDTH-1:0], 1'b0};
            end
        end else begin
            n_acc = i_x[0] ? i_acc + i_y : i_acc;
            n_x   = {1'b0, i_x[WIDTH:1]};
            n_y   = {i_y[WIDTH-1:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_is_div <= i_is_div;
            o_acc    <= n_acc;
            o_x      <= n_x;
            o_y      <= n_y;
            o_side   <= i_side;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/signed_shift_add_alu.sv =====
// Signed ALU: add, subtract, multiply, quotient, remainder on WIDTH-bit operands.
// Request channel i_req carries cmd, a, b; response channel o_rsp carries
// result, carry and div_by_zero, one response per request, in order.
// One request is taken every cycle while the response side keeps up.
// An input register forms magnitudes, WIDTH cells each do one shift-add or
// one restoring-divide step, and the output register fixes signs.
// Each of the WIDTH cells takes one step per cycle while the row is not stalled.
// A stall at the response side freezes the whole row; i_req.ready drops
// only while the output register holds a response that is not taken.
// Synchronous reset empties the row; no request is lost after reset ends.
`default_nettype none
module signed_shift_add_alu #(
    parameter int unsigned WIDTH = ssa_pkg::WIDTH_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    ssa_req_if.sink   i_req,
    ssa_rsp_if.source o_rsp
);
    import ssa_pkg::*;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             na;
        logic             nb;
        logic             bz;
        logic [WIDTH-1:0] a;
    } t_side;
    localparam int unsigned SW = $bits(t_side);

    logic en;
    logic [WIDTH:0]   acc [WIDTH+1];
    logic [WIDTH:0]   xx  [WIDTH+1];
    logic [WIDTH:0]   yy  [WIDTH+1];
    logic [SW-1:0]    sd  [WIDTH+1];
    logic             vl  [WIDTH+1];
    logic             dv  [WIDTH+1];

    logic r_v0;
    logic r_ovalid;
    assign en = !r_ovalid || o_rsp.ready;
    assign i_req.ready = en;

    logic [WIDTH-1:0] r_fast;
    logic             r_carry;
    logic [WIDTH:0]   n_ma, n_mb;
    logic [WIDTH:0]   n_sum;
    logic [WIDTH-1:0] n_bop;
    t_side            n_sd;

    always_comb begin
        n_sd.cmd = i_req.cmd;
        n_sd.na  = i_req.a[WIDTH-1];
        n_sd.nb  = i_req.b[WIDTH-1];
        n_sd.bz  = (i_req.b == '0);
        n_sd.a   = i_req.a;
        n_ma = n_sd.na ? -{1'b1, i_req.a} : {1'b0, i_req.a};
        n_mb = n_sd.nb ? -{1'b1, i_req.b} : {1'b0, i_req.b};
        n_bop = (i_req.cmd == CMD_SUB) ? -i_req.b : i_req.b;
        n_sum = {1'b0, i_req.a} + {1'b0, n_bop};
    end

    logic [WIDTH:0] r_acc0, r_x0, r_y0;
    logic [SW-1:0]  r_sd0;
    logic           r_dv0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_req.valid;
        end
        if (en) begin
            r_dv0  <= (i_req.cmd == CMD_DIV) || (i_req.cmd == CMD_MOD);
            r_acc0 <= '0;
            r_x0   <= ((i_req.cmd == CMD_DIV) || (i_req.cmd == CMD_MOD))
                      ? {n_ma[WIDTH-1:0], 1'b0} : {1'b0, i_req.a};
            r_y0   <= ((i_req.cmd == CMD_DIV) || (i_req.cmd == CMD_MOD)) ? n_mb
                      : {1'b0, i_req.b};
            r_sd0  <= n_sd;
            r_fast <= n_sum[WIDTH-1:0];
            r_carry <= n_sum[WIDTH];
        end
    end

    // Add and sub results ride alongside in a side register chain.
    logic [WIDTH:0] fs [WIDTH+1];
    assign acc[0] = r_acc0;
    assign xx[0]  = r_x0;
    assign yy[0]  = r_y0;
    assign sd[0]  = r_sd0;
    assign vl[0]  = r_v0;
    assign dv[0]  = r_dv0;
    assign fs[0]  = {r_carry, r_fast};

    for (genvar g = 0; g < WIDTH; g++) begin : g_cell
        logic [WIDTH-1:0] side_o;
        ssa_cell #(.WIDTH(WIDTH)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(vl[g]), .i_is_div(dv[g]),
            .i_acc(acc[g]), .i_x(xx[g]), .i_y(yy[g]),
            .i_side(sd[g][WIDTH-1:0]),
            .o_valid(vl[g+1]), .o_is_div(dv[g+1]),
            .o_acc(acc[g+1]), .o_x(xx[g+1]), .o_y(yy[g+1]),
            .o_side(side_o)
        );
        logic [SW-WIDTH-1:0] r_hi;
        logic [WIDTH:0]      r_fs;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_hi <= sd[g][SW-1:WIDTH];
                r_fs <= fs[g];
            end
        end
        assign sd[g+1] = {r_hi, side_o};
        assign fs[g+1] = r_fs;
    end

    t_side            fin;
    logic [WIDTH-1:0] q, r, n_res;
    logic             n_c, n_dz;
    always_comb begin
        fin  = t_side'(sd[WIDTH]);
        q    = xx[WIDTH][WIDTH-1:0];
        r    = acc[WIDTH][WIDTH-1:0];
        if (fin.na != fin.nb) q = -q;
        if (fin.na) r = -r;
        n_res = '0;
        n_c   = 1'b0;
        n_dz  = 1'b0;
        unique case (fin.cmd)
            CMD_ADD, CMD_SUB: begin
                n_res = fs[WIDTH][WIDTH-1:0];
                n_c   = fs[WIDTH][WIDTH];
            end
            CMD_MUL: n_res = acc[WIDTH][WIDTH-1:0];
            CMD_DIV: begin
                n_dz  = fin.bz;
                n_res = fin.bz ? '1 : q;
            end
            CMD_MOD: begin
                n_dz  = fin.bz;
                n_res = fin.bz ? fin.a : r;
            end
            default: n_res = '0;
        endcase
    end

    logic [WIDTH-1:0] r_res;
    logic             r_c, r_dz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_ovalid <= vl[WIDTH];
        end
        if (en) begin
            r_res <= n_res;
            r_c   <= n_c;
            r_dz  <= n_dz;
        end
    end

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.result      = r_res;
    assign o_rsp.carry       = r_c;
    assign o_rsp.div_by_zero = r_dz;
endmodule
`default_nettype wire

// ===== hw/rtl/ssa_checker.sv =====
`default_nettype none
module ssa_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_req_valid,
    input wire logic i_req_ready,
    input wire logic i_rsp_valid,
    input wire logic i_rsp_ready,
    input wire logic i_carry,
    input wire logic i_dz
);
    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |-> !i_req_ready) else $error("ready while stalled");
    a_free_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rsp_valid |-> i_req_ready) else $error("not ready while empty");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !(i_carry && i_dz)) else $error("carry and div_by_zero both set");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid) else $error("response dropped");
endmodule

bind signed_shift_add_alu ssa_checker u_ssa_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_req_valid(i_req.valid), .i_req_ready(i_req.ready),
    .i_rsp_valid(o_rsp.valid), .i_rsp_ready(o_rsp.ready),
    .i_carry(o_rsp.carry), .i_dz(o_rsp.div_by_zero)
);
`default_nettype wire

// ===== tb/signed_shift_add_alu_tb.sv =====
`default_nettype none
module signed_shift_add_alu_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ssa_pkg::*;

    localparam int unsigned W = 32;
    localparam int LIMIT = 2000000;

    typedef struct packed {
        logic [W-1:0] result;
        logic         carry;
        logic         div_by_zero;
    } alu_rsp_t;

    class alu_scoreboard;
        alu_rsp_t pending[$];
        int errors = 0;

        function automatic logic [W-1:0] neg(logic [W-1:0] x);
            return ~x + 1'b1;
        endfunction

        function automatic alu_rsp_t compute(logic [2:0] cmd, logic [W-1:0] a,
                                             logic [W-1:0] b);
            alu_rsp_t r;
            logic [W:0] s;
            logic [W-1:0] ma, mb, q, rm;
            logic na, nb;
            r = '0;
            na = a[W-1];
            nb = b[W-1];
            case (cmd)
                CMD_ADD: begin
                    s = {1'b0, a} + {1'b0, b};
                    r.result = s[W-1:0];
                    r.carry = s[W];
                end
                CMD_SUB: begin
                    s = {1'b0, a} + {1'b0, neg(b)};
                    r.result = s[W-1:0];
                    r.carry = s[W];
                end
                CMD_MUL: r.result = a * b;
                CMD_DIV, CMD_MOD: begin
                    if (b == '0) begin
                        r.div_by_zero = 1'b1;
                        r.result = (cmd == CMD_DIV) ? '1 : a;
                    end else begin
                        ma = na ? neg(a) : a;
                        mb = nb ? neg(b) : b;
                        q = ma / mb;
                        rm = ma % mb;
                        if (na != nb) q = neg(q);
                        if (na) rm = neg(rm);
                        r.result = (cmd == CMD_DIV) ? q : rm;
                    end
                end
                default: r = '0;
            endcase
            return r;
        endfunction

        function void note_request(logic [2:0] cmd, logic [W-1:0] a, logic [W-1:0] b);
            pending.push_back(compute(cmd, a, b));
        endfunction

        function void check_response(alu_rsp_t got);
            alu_rsp_t exp;
            if (pending.size() == 0) begin
                $display("%0t unexpected response %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.result !== exp.result) begin
                $display("%0t result exp %h got %h", $time, exp.result, got.result);
                errors++;
            end
            if (got.carry !== exp.carry) begin
                $display("%0t carry exp %b got %b", $time, exp.carry, got.carry);
                errors++;
            end
            if (got.div_by_zero !== exp.div_by_zero) begin
                $display("%0t div_by_zero exp %b got %b", $time, exp.div_by_zero,
                         got.div_by_zero);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int cycles = 0;
    alu_scoreboard sb = new();

    ssa_req_if #(.WIDTH(W)) req_if();
    ssa_rsp_if #(.WIDTH(W)) rsp_if();

    signed_shift_add_alu #(.WIDTH(W)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_if.sink), .o_rsp(rsp_if.source)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        req_if.valid = 1'b0;
        req_if.cmd = '0;
        req_if.a = '0;
        req_if.b = '0;
        rsp_if.ready = 1'b0;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic logic [W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            4: return $urandom_range(0, 20);
            5: return -$urandom_range(1, 20);
            6: return $urandom() >> $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_request(logic [2:0] cmd, logic [W-1:0] a, logic [W-1:0] b);
        req_if.valid <= 1'b1;
        req_if.cmd <= cmd;
        req_if.a <= a;
        req_if.b <= b;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(cmd, a, b);
    endtask

    task automatic idle_request(int n);
        if (n > 0) begin
            req_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_with_gap(logic [2:0] cmd, logic [W-1:0] a, logic [W-1:0] b,
                                 bit gaps);
        if (gaps) idle_request(gap_len());
        send_request(cmd, a, b);
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_response({rsp_if.result, rsp_if.carry, rsp_if.div_by_zero});
    end

    initial begin : resp_stall
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            n = gap_len();
            if (n > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        wait (cycles >= LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        logic [W-1:0] ext[6];
        ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h1, 32'h5555_aaaa};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int c = 0; c < 8; c++)
            send_with_gap(c[2:0], ext[c % 6], ext[(c + 2) % 6], 1'b0);
        send_request(CMD_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_request(CMD_MOD, 32'h8000_0000, 32'hffff_ffff);
        send_request(CMD_DIV, 32'hffff_fff9, 32'h0);
        send_request(CMD_MOD, 32'hffff_fff9, 32'h0);
        send_request(CMD_SUB, 32'h1234, 32'h0);
        send_request(CMD_MOD, 32'hffff_fff9, 32'h2);
        send_request(CMD_DIV, 32'h7, 32'hffff_fffe);
        send_request(CMD_MUL, 32'h8000_0000, 32'hffff_ffff);
        send_request(CMD_ADD, 32'hffff_ffff, 32'h1);
        send_request(CMD_DIV, 32'h8000_0000, 32'h8000_0000);
        idle_request(1);
        wait (sb.pending.size() == 0);
        for (int i = 0; i < 1600; i++) begin
            logic [2:0] c;
            c = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
            send_with_gap(c, pick_operand(), pick_operand(), i % 400 >= 100);
            if (i == 800) begin
                idle_request(1);
                wait (sb.pending.size() == 0);
            end
        end
        req_if.valid <= 1'b0;
        wait (sb.pending.size() == 0);
        repeat (2 * W + 10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== signed_shift_add_alu.f =====
hw/rtl/ssa_pkg.sv
hw/rtl/ssa_if.sv
hw/rtl/ssa_cell.sv
hw/rtl/signed_shift_add_alu.sv
hw/rtl/ssa_checker.sv
tb/signed_shift_add_alu_tb.sv
